[hw/rtl/swr_pkg.sv]
package swr_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 5;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam logic [5:0] FRAME_BITS_COUNT = 6'(FRAME_BITS);

  // configuration register indexes
  localparam logic [1:0] REG_START_LOW_TICKS  = 2'd0;
  localparam logic [1:0] REG_RELEASE_TICKS    = 2'd1;
  localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_SAMPLE_DELAY     = 2'd3;

  // configuration reset values
  localparam logic [15:0] START_LOW_TICKS_RESET  = 16'd20000;
  localparam logic [7:0]  RELEASE_TICKS_RESET    = 8'd30;
  localparam logic [7:0]  RESPONSE_TIMEOUT_RESET = 8'd100;
  localparam logic [7:0]  SAMPLE_DELAY_RESET     = 8'd40;

  // input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // read status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_LOW = 4'd1,
    PH_RELEASE   = 4'd2,
    PH_RESP_LOW  = 4'd3,
    PH_RESP_HIGH = 4'd4,
    PH_RESP_END  = 4'd5,
    PH_BIT_HIGH  = 4'd6,
    PH_BIT_DELAY = 4'd7,
    PH_BIT_LOW   = 4'd8
  } phase_t;

  typedef struct packed {
    logic opcode;
    logic line_level;
  } in_word_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_value;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] temperature;
    logic [7:0] humidity;
  } out_word_t;

  // byte i of the frame, byte 0 received first
  function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] frame, input int idx);
    return frame[8*(FRAME_BYTES-1-idx) +: 8];
  endfunction

  // sum of the leading bytes modulo 256 against the trailing byte
  function automatic logic frame_sum_ok(input logic [FRAME_BITS-1:0] frame);
    logic [7:0] sum;
    sum = 8'd0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      sum = sum + frame_byte(frame, i);
    end
    return sum == frame_byte(frame, FRAME_BYTES - 1);
  endfunction

endpackage

[hw/rtl/single_wire_sensor_frame_reader_core.sv]
// Single-wire sensor frame reader.
// Input channel (in_valid/in_ready/in_data): one word per microsecond tick,
// carrying the sampled data line level, or a start command (opcode 1).
// Every accepted word yields exactly one output word (out_valid/out_ready/
// out_data) with the line drive controls, busy, a one-word done pulse, the
// status of the last finished read and the humidity and temperature bytes
// of the last frame whose checksum matched.
// The state update and the output word are computed in the cycle of
// acceptance and the output word is registered. One word
// is accepted every cycle; the single output register is the only limit,
// so in_ready drops only while a word waits and out_ready is low.
// Configuration: cfg_we with cfg_index and cfg_data writes a register;
// write only while no read is in progress.
// Reset (rst, synchronous) returns to idle with status ok, zeroed bytes and
// default timing registers; the output register comes up empty.
module single_wire_sensor_frame_reader_core
  import swr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] start_low_ticks;
  logic [7:0]  release_ticks;
  logic [7:0]  response_timeout;
  logic [7:0]  sample_delay;

  phase_t                phase, phase_next;
  logic [15:0]           tick_count, tick_count_next;
  logic [5:0]            bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [1:0]            last_status, last_status_next;
  logic [7:0]            temp_reg, temp_reg_next;
  logic [7:0]            humid_reg, humid_reg_next;
  logic                  done_next;

  logic        in_fire;
  logic [15:0] tick_inc;
  logic [5:0]  bit_inc;
  logic        want_level;
  logic        level_hit;
  logic        budget_spent;
  out_word_t   result;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks  <= START_LOW_TICKS_RESET;
      release_ticks    <= RELEASE_TICKS_RESET;
      response_timeout <= RESPONSE_TIMEOUT_RESET;
      sample_delay     <= SAMPLE_DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_LOW_TICKS:  start_low_ticks  <= cfg_data;
        REG_RELEASE_TICKS:    release_ticks    <= cfg_data[7:0];
        REG_RESPONSE_TIMEOUT: response_timeout <= cfg_data[7:0];
        REG_SAMPLE_DELAY:     sample_delay     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // level wait helpers
  assign tick_inc     = tick_count + 16'd1;
  assign bit_inc      = bit_index + 6'd1;
  assign want_level   = (phase == PH_RESP_HIGH) || (phase == PH_BIT_HIGH);
  assign level_hit    = in_data.line_level == want_level;
  assign budget_spent = tick_count >= {8'd0, response_timeout};

  // next state for one accepted word
  always_comb begin
    phase_next       = phase;
    tick_count_next  = tick_count;
    bit_index_next   = bit_index;
    frame_shift_next = frame_shift;
    last_status_next = last_status;
    temp_reg_next    = temp_reg;
    humid_reg_next   = humid_reg;
    done_next        = 1'b0;

    if (in_data.opcode == OP_START) begin
      if (phase == PH_IDLE) begin
        phase_next       = PH_START_LOW;
        tick_count_next  = 16'd0;
        bit_index_next   = 6'd0;
        frame_shift_next = '0;
      end
    end else begin
      case (phase)
        PH_IDLE: ;
        PH_START_LOW: begin
          tick_count_next = tick_inc;
          if (tick_inc >= start_low_ticks) begin
            phase_next      = PH_RELEASE;
            tick_count_next = 16'd0;
          end
        end
        PH_RELEASE: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {8'd0, release_ticks}) begin
            phase_next      = PH_RESP_LOW;
            tick_count_next = 16'd0;
          end
        end
        PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END: begin
          if (level_hit) begin
            tick_count_next = 16'd0;
            case (phase)
              PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
              PH_RESP_HIGH: phase_next = PH_RESP_END;
              default:      phase_next = PH_BIT_HIGH;
            endcase
          end else if (budget_spent) begin
            phase_next       = PH_IDLE;
            tick_count_next  = 16'd0;
            last_status_next = ST_TIMEOUT;
            done_next        = 1'b1;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        PH_BIT_HIGH: begin
          // a timeout inside a bit counts as the level arriving
          if (level_hit || budget_spent) begin
            phase_next      = PH_BIT_DELAY;
            tick_count_next = 16'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        PH_BIT_DELAY: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {8'd0, sample_delay}) begin
            frame_shift_next = {frame_shift[FRAME_BITS-2:0], in_data.line_level};
            phase_next       = PH_BIT_LOW;
            tick_count_next  = 16'd0;
          end
        end
        PH_BIT_LOW: begin
          if (level_hit || budget_spent) begin
            bit_index_next  = bit_inc;
            tick_count_next = 16'd0;
            if (bit_inc >= FRAME_BITS_COUNT) begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
              if (frame_sum_ok(frame_shift)) begin
                last_status_next = ST_OK;
                humid_reg_next   = frame_byte(frame_shift, 0);
                temp_reg_next    = frame_byte(frame_shift, 2);
              end else begin
                last_status_next = ST_CHECKSUM;
              end
            end else begin
              phase_next = PH_BIT_HIGH;
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    result.drive_enable = (phase_next == PH_START_LOW) || (phase_next == PH_RELEASE);
    result.drive_value  = phase_next == PH_RELEASE;
    result.busy_res     = phase_next != PH_IDLE;
    result.done_res     = done_next;
    result.status       = last_status_next;
    result.temperature  = temp_reg_next;
    result.humidity     = humid_reg_next;
  end

  // reader state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      tick_count  <= 16'd0;
      bit_index   <= 6'd0;
      frame_shift <= '0;
      last_status <= ST_OK;
      temp_reg    <= 8'd0;
      humid_reg   <= 8'd0;
    end else if (in_fire) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      frame_shift <= frame_shift_next;
      last_status <= last_status_next;
      temp_reg    <= temp_reg_next;
      humid_reg   <= humid_reg_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

  // checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done word reports busy");

  a_value_needs_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_value |-> out_data.drive_enable)
    else $error("drive value high while line released");

  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index <= FRAME_BITS_COUNT)
    else $error("bit index past frame length");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.opcode == OP_START && phase == PH_IDLE
      |=> phase == PH_START_LOW && out_valid && out_data.drive_enable)
    else $error("start command did not begin a read");

endmodule
